### sv/sctp_data_chunk_extractor_unit_macros.svh
// assertion macros for the sctp data chunk extractor
`ifndef SCTP_DATA_CHUNK_EXTRACTOR_UNIT_MACROS_SVH
`define SCTP_DATA_CHUNK_EXTRACTOR_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define SDCE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define SDCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### sv/sdce_pkg.sv
// shared types and constants for the sctp data chunk extractor
`timescale 1ns / 1ps
package sdce_pkg;
    localparam int MAX_FRAME_BYTES_DEF = 16384;
    localparam int MAX_EXT_HEADERS_DEF = 8;
    localparam int LEN_W = 15;
    localparam int CNT_W = 11;
    localparam logic [31:0] PPID_FIRST_RST = 32'd18;
    localparam logic [31:0] PPID_SECOND_RST = 32'd60;
    localparam logic [7:0] PROTO_SCTP = 8'd132;
    localparam logic [15:0] ETH_CTAG = 16'h8100;
    localparam logic [15:0] ETH_QINQ = 16'h88A8;
    localparam logic [15:0] ETH_IP4 = 16'h0800;
    localparam logic [15:0] ETH_IP6 = 16'h86DD;
    localparam logic [7:0] NH_HOP = 8'd0;
    localparam logic [7:0] NH_ROUTE = 8'd43;
    localparam logic [7:0] NH_FRAG = 8'd44;
    localparam logic [7:0] NH_DEST = 8'd60;

    typedef enum logic { CFG_PPID_FIRST = 1'b0, CFG_PPID_SECOND = 1'b1 } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_LINK, PH_IP4, PH_IP6, PH_EXT, PH_CHUNK, PH_DONE
    } phase_t;

    // item passed from the front parser to the result stage
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] payload_byte;
        logic       ppid_is_second;
        logic       payload_start;
        logic       payload_end;
        logic       frame_done;
        logic [CNT_W-1:0] payload_count;
    } res_t;

    function automatic logic is_ip(input logic [15:0] t);
        return (t == ETH_IP4) || (t == ETH_IP6);
    endfunction
endpackage

### sv/sdce_parser.sv
// front part: per-byte header walk and chunk classification
`timescale 1ns / 1ps
module sdce_parser #(
    parameter int MAX_FRAME_BYTES = sdce_pkg::MAX_FRAME_BYTES_DEF,
    parameter int MAX_EXT_HEADERS = sdce_pkg::MAX_EXT_HEADERS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step,
    input  logic [7:0]               data_byte,
    input  logic [sdce_pkg::LEN_W-1:0] frame_len,
    input  logic                     frame_end,
    input  logic [31:0]              ppid_first,
    input  logic [31:0]              ppid_second,
    output logic                     res_push,
    output sdce_pkg::res_t           res_item
);
    import sdce_pkg::*;

    localparam logic [17:0] MAXF = 18'(MAX_FRAME_BYTES);
    localparam logic [3:0]  MAXE = 4'(MAX_EXT_HEADERS);

    // 18-bit arithmetic holds offsets plus lengths without wrap
    logic [LEN_W-1:0] pos_reg, pos_next;
    phase_t           ph_reg, ph_next;
    logic [15:0]      ltw_reg, ltw_next;
    logic [17:0]      off_reg, off_next;
    logic [7:0]       np_reg, np_next;
    logic [3:0]       ext_reg, ext_next;
    logic [7:0]       ctype_reg, ctype_next;
    logic [15:0]      clen_reg, clen_next;
    logic [31:0]      acc_reg, acc_next;
    logic [CNT_W-1:0] found_reg, found_next;
    logic [15:0]      hw_reg, hw_next;
    logic [7:0]       hb_reg, hb_next;
    logic [17:0]      ul_reg, ul_next;
    logic [1:0]       ms_reg, ms_next;
    res_t             r;
    logic             emit;

    logic [17:0] len, pos, rel, clen, o, c;
    logic [15:0] inner, hwn;
    logic [17:0] ip4_ul;

    always_comb begin
        len = 18'(frame_len);
        pos = 18'(pos_reg);
        rel = pos - off_reg;
        pos_next = pos_reg; ph_next = ph_reg; ltw_next = ltw_reg; off_next = off_reg;
        np_next = np_reg; ext_next = ext_reg; ctype_next = ctype_reg; clen_next = clen_reg;
        acc_next = acc_reg; found_next = found_reg; hw_next = hw_reg; hb_next = hb_reg;
        ul_next = ul_reg; ms_next = ms_reg;
        r = '0;
        emit = 1'b0;
        clen = 18'(clen_reg);
        o = '0; c = '0;
        inner = {hb_reg, data_byte};
        hwn = {hw_reg[7:0], data_byte};
        ip4_ul = 18'({data_byte[3:0], 2'b00});

        if (pos < len && ph_reg != PH_DONE) begin
            case (ph_reg)
                PH_LINK: begin
                    if (pos == 18'd0 && (len < 18'd16 || len > MAXF)) begin
                        ph_next = PH_DONE;
                    end else if (pos == 18'd12) begin
                        ltw_next = {data_byte, 8'h00};
                    end else if (pos == 18'd13) begin
                        ltw_next = {ltw_reg[15:8], data_byte};
                        if (ltw_next == ETH_CTAG || ltw_next == ETH_QINQ) begin
                            if (len < 18'd18) ph_next = PH_DONE;
                        end else if (is_ip(ltw_next)) begin
                            off_next = 18'd14;
                            ph_next = (ltw_next == ETH_IP4) ? PH_IP4 : PH_IP6;
                        end
                    end else if (pos == 18'd14) begin
                        hw_next = {8'h00, data_byte};
                    end else if (pos == 18'd15) begin
                        hw_next = hwn;
                        if (ltw_reg != ETH_CTAG && ltw_reg != ETH_QINQ) begin
                            if (is_ip(hwn)) begin
                                ltw_next = hwn; off_next = 18'd16;
                                ph_next = (hwn == ETH_IP4) ? PH_IP4 : PH_IP6;
                            end else ph_next = PH_DONE;
                        end
                    end else if (pos == 18'd16) begin
                        hb_next = data_byte;
                    end else if (pos == 18'd17) begin
                        if (is_ip(inner)) begin
                            ltw_next = inner; off_next = 18'd18;
                            ph_next = (inner == ETH_IP4) ? PH_IP4 : PH_IP6;
                        end else if (is_ip(hw_reg)) begin
                            // byte 16 replayed as first byte of the ip header
                            ltw_next = hw_reg; off_next = 18'd16;
                            if (hw_reg == ETH_IP4) begin
                                ph_next = PH_IP4;
                                ul_next = 18'({hb_reg[3:0], 2'b00});
                                if (hb_reg[7:4] != 4'd4 || len < 18'd36 ||
                                    len < 18'd16 + ul_next) ph_next = PH_DONE;
                            end else begin
                                ph_next = PH_IP6;
                                if (hb_reg[7:4] != 4'd6 || len < 18'd56) ph_next = PH_DONE;
                            end
                        end else ph_next = PH_DONE;
                    end
                end
                PH_IP4: begin
                    if (pos >= off_reg) begin
                        if (rel == 18'd0) begin
                            ul_next = ip4_ul;
                            if (data_byte[7:4] != 4'd4 || len < off_reg + 18'd20 ||
                                len < off_reg + ip4_ul) ph_next = PH_DONE;
                        end else if (rel == 18'd9) begin
                            np_next = data_byte;
                            c = off_reg + ul_reg + 18'd12;
                            if (data_byte != PROTO_SCTP || len < c) ph_next = PH_DONE;
                            else if (c + 18'd4 > len) ph_next = PH_DONE;
                            else begin
                                off_next = c; ph_next = PH_CHUNK; ctype_next = '0;
                                clen_next = '0; acc_next = '0; ul_next = '0; ms_next = '0;
                            end
                        end
                    end
                end
                PH_IP6, PH_EXT: begin
                    if (pos >= off_reg) begin
                        o = '1;
                        if (ph_reg == PH_IP6) begin
                            if (rel == 18'd0) begin
                                if (data_byte[7:4] != 4'd6 || len < off_reg + 18'd40)
                                    ph_next = PH_DONE;
                            end else if (rel == 18'd6) np_next = data_byte;
                            else if (rel == 18'd39) o = off_reg + 18'd40;
                        end else begin
                            if (rel == 18'd0) hb_next = data_byte;
                            else if (rel == 18'd1) begin
                                ul_next = 18'({data_byte, 3'b000}) + 18'd8;
                                if (len < off_reg + ul_next) ph_next = PH_DONE;
                                else begin
                                    np_next = hb_reg; ext_next = ext_reg + 4'd1;
                                end
                            end else if (rel + 18'd1 == ul_reg) o = off_reg + ul_reg;
                        end
                        // choose the next extension header or the sctp header
                        if (o != '1) begin
                            if (np_reg == PROTO_SCTP || ext_reg >= MAXE || o >= len) begin
                                c = o + 18'd12;
                                if (np_reg != PROTO_SCTP || len < c || c + 18'd4 > len)
                                    ph_next = PH_DONE;
                                else begin
                                    off_next = c; ph_next = PH_CHUNK; ctype_next = '0;
                                    clen_next = '0; acc_next = '0; ul_next = '0;
                                    ms_next = '0;
                                end
                            end else if ((np_reg == NH_HOP || np_reg == NH_ROUTE ||
                                          np_reg == NH_FRAG || np_reg == NH_DEST) &&
                                         len >= o + 18'd8) begin
                                off_next = o; ph_next = PH_EXT; ul_next = '0;
                            end else ph_next = PH_DONE;
                        end
                    end
                end
                PH_CHUNK: begin
                    if (pos >= off_reg) begin
                        if (rel == 18'd0) ctype_next = data_byte;
                        else if (rel == 18'd2) clen_next = {data_byte, 8'h00};
                        else if (rel == 18'd3) begin
                            clen_next = {clen_reg[15:8], data_byte};
                            clen = 18'(clen_next);
                        end
                        if (rel == 18'd3 && (clen < 18'd4 || off_reg + clen > len)) begin
                            ph_next = PH_DONE;
                        end else begin
                            if (rel == 18'd3) ul_next = (clen + 18'd3) & ~18'd3;
                            if (rel >= 18'd12 && rel <= 18'd15 && ctype_reg == 8'd0 &&
                                clen >= 18'd16) begin
                                acc_next = {acc_reg[23:0], data_byte};
                                if (rel == 18'd15) begin
                                    if (acc_next == ppid_first) ms_next = 2'd1;
                                    else if (acc_next == ppid_second) ms_next = 2'd2;
                                    else ms_next = 2'd0;
                                end
                            end
                            if (ms_reg != 2'd0 && rel >= 18'd16 && rel < clen) begin
                                emit = 1'b1;
                                r.byte_valid = 1'b1;
                                r.payload_byte = data_byte;
                                r.ppid_is_second = (ms_reg == 2'd2);
                                r.payload_start = (rel == 18'd16);
                                r.payload_end = (rel + 18'd1 == clen);
                                if (r.payload_end && found_reg != '1)
                                    found_next = found_reg + CNT_W'(1);
                            end
                            if (rel >= 18'd3 && rel + 18'd1 == ul_next) begin
                                c = off_reg + ul_next;
                                if (c + 18'd4 > len) ph_next = PH_DONE;
                                else begin
                                    off_next = c; ph_next = PH_CHUNK; ctype_next = '0;
                                    clen_next = '0; acc_next = '0; ul_next = '0;
                                    ms_next = '0;
                                end
                            end
                        end
                    end
                end
                default: ph_next = PH_DONE;
            endcase
        end

        if (frame_end) begin
            r.frame_done = 1'b1;
            r.payload_count = found_next;
            pos_next = '0; ph_next = PH_LINK; ltw_next = '0; off_next = '0; np_next = '0;
            ext_next = '0; ctype_next = '0; clen_next = '0; acc_next = '0;
            found_next = '0; hw_next = '0; hb_next = '0; ul_next = '0; ms_next = '0;
        end else if (pos_reg != '1) begin
            pos_next = pos_reg + LEN_W'(1);
        end
    end

    assign res_push = step && (emit || frame_end);
    assign res_item = r;

    // parse state advances once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0; ph_reg <= PH_LINK; ltw_reg <= '0; off_reg <= '0; np_reg <= '0;
            ext_reg <= '0; ctype_reg <= '0; clen_reg <= '0; acc_reg <= '0;
            found_reg <= '0; hw_reg <= '0; hb_reg <= '0; ul_reg <= '0; ms_reg <= '0;
        end else if (step) begin
            pos_reg <= pos_next; ph_reg <= ph_next; ltw_reg <= ltw_next;
            off_reg <= off_next; np_reg <= np_next; ext_reg <= ext_next;
            ctype_reg <= ctype_next; clen_reg <= clen_next; acc_reg <= acc_next;
            found_reg <= found_next; hw_reg <= hw_next; hb_reg <= hb_next;
            ul_reg <= ul_next; ms_reg <= ms_next;
        end
    end
endmodule

### sv/sdce_queue.sv
// back part: two-entry result queue feeding the output channel
`timescale 1ns / 1ps
module sdce_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sdce_pkg::res_t push_item,
    output logic           space,
    output logic           out_valid,
    input  logic           out_ready,
    output sdce_pkg::res_t out_item
);
    import sdce_pkg::*;

    res_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign pop = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item = mem_reg[rp_reg];
    // a same-cycle pop counts as room; input waits only if full and stalled
    assign space = (cnt_reg != 2'd2) || out_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_item;
    end
endmodule

### sv/sctp_data_chunk_extractor_unit.sv
// top level of the sctp data chunk extractor
`timescale 1ns / 1ps
// Takes one frame byte per cycle and passes on the payload bytes of sctp
// DATA chunks whose ppid matches ppid_first or ppid_second, with a summary
// item carrying the payload count on the frame's last byte. Each byte is
// parsed combinationally by the front parser, so one item is accepted every
// clock; a two-entry result queue decouples the output so input keeps flowing
// unless that queue is full and the output is stalled.
module sctp_data_chunk_extractor_unit #(
    parameter int MAX_FRAME_BYTES = sdce_pkg::MAX_FRAME_BYTES_DEF,
    parameter int MAX_EXT_HEADERS = sdce_pkg::MAX_EXT_HEADERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], frame_len[22:8], zero pad
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // byte_valid, payload_byte, ppid_is_second,
                                   // payload_start, payload_end, payload_count, pad
    output logic        m_tlast,   // frame_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import sdce_pkg::*;

    logic [31:0] ppid_first_reg, ppid_second_reg;
    logic        space, push, step;
    res_t        pitem, qitem;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppid_first_reg <= PPID_FIRST_RST;
            ppid_second_reg <= PPID_SECOND_RST;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PPID_FIRST:  ppid_first_reg <= cfg_data;
                CFG_PPID_SECOND: ppid_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = space;
    assign step = s_tvalid && space;

    sdce_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .MAX_EXT_HEADERS(MAX_EXT_HEADERS)
    ) u_parser (
        .aclk(aclk), .aresetn(aresetn), .step(step),
        .data_byte(s_tdata[7:0]), .frame_len(s_tdata[22:8]), .frame_end(s_tlast),
        .ppid_first(ppid_first_reg), .ppid_second(ppid_second_reg),
        .res_push(push), .res_item(pitem)
    );

    sdce_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_item(pitem),
        .space(space), .out_valid(m_tvalid), .out_ready(m_tready), .out_item(qitem)
    );

    // output packing
    assign m_tdata = {9'h000, qitem.payload_count, qitem.payload_end,
                      qitem.payload_start, qitem.ppid_is_second,
                      qitem.payload_byte, qitem.byte_valid};
    assign m_tlast = qitem.frame_done;
endmodule

### sv/sdce_checker.sv
// port-level checker for the sctp data chunk extractor
`timescale 1ns / 1ps
`include "sctp_data_chunk_extractor_unit_macros.svh"
module sdce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    // a held output item stays
    `SDCE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "held item changed")
    // count field only on a frame-end item
    `SDCE_ASSERT_IMPL(a_cnt, m_tvalid && !m_tlast, m_tdata[22:12] == 11'd0, "count outside frame end")
    // every output item carries a byte or ends a frame
    `SDCE_ASSERT_IMPL(a_kind, m_tvalid, m_tdata[0] || m_tlast, "empty output item")
    // input is ready whenever the output is ready
    `SDCE_ASSERT_IMPL(a_flow, m_tready, s_tready, "input stalled with output ready")
endmodule

bind sctp_data_chunk_extractor_unit sdce_checker u_sdce_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
